FILE: rtl/core/sfv_pkg.sv
// ----------------------------------------------------------------------------
// Frame validator package
// Shared constants, codes, header layout, structs and byte-wide CRC functions.
// ----------------------------------------------------------------------------
package sfv_pkg;

   localparam int HEADER_BYTES = 36;
   localparam int POS_W        = 17;
   localparam int REMAIN_W     = 16;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic [POS_W-1:0] POS_MAX = '1;

   // Header byte offsets (little-endian multi-byte fields).
   localparam int OFS_MAGIC    = 0;
   localparam int OFS_VERSION  = 2;
   localparam int OFS_KIND     = 3;
   localparam int OFS_HDR_SIZE = 4;
   localparam int OFS_FLAGS    = 5;
   localparam int OFS_PAY_SIZE = 6;
   localparam int OFS_SENDER   = 8;
   localparam int OFS_RECEIVER = 9;
   localparam int OFS_EPOCH    = 10;
   localparam int OFS_RUN      = 14;
   localparam int OFS_SEQUENCE = 18;
   localparam int OFS_ACKED    = 22;
   localparam int OFS_TIME     = 26;
   localparam int OFS_HDR_CRC  = 30;
   localparam int OFS_PAY_CRC  = 32;

   localparam logic [15:0] CRC16_INIT = 16'hFFFF;
   localparam logic [15:0] CRC16_TOP  = 16'h8000;
   localparam logic [15:0] CRC16_POLY = 16'h1021;
   localparam logic [31:0] CRC32_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC32_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC32_XOR  = 32'hFFFF_FFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAGIC     = 3'd0,
      CSR_VERSION   = 3'd1,
      CSR_LOW_TYPE  = 3'd2,
      CSR_HIGH_TYPE = 3'd3,
      CSR_PAY_LIMIT = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      VERDICT_OK       = 4'd0,
      VERDICT_SIZE     = 4'd1,
      VERDICT_MAGIC    = 4'd2,
      VERDICT_VERSION  = 4'd3,
      VERDICT_TYPE     = 4'd4,
      VERDICT_HDR_SIZE = 4'd5,
      VERDICT_PAYLIMIT = 4'd6,
      VERDICT_HDR_CRC  = 4'd7,
      VERDICT_PAY_CRC  = 4'd8
   } verdict_type;

   typedef logic [HEADER_BYTES-1:0][7:0] header_type;

   typedef struct packed {
      logic [15:0] magic;
      logic [7:0]  version;
      logic [7:0]  low_type;
      logic [7:0]  high_type;
      logic [15:0] pay_limit;
   } cfg_type;

   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  kind;
      logic [7:0]  flag_bits;
      logic [7:0]  sender_slot;
      logic [7:0]  receiver_mask;
      logic [15:0] body_length;
      logic [31:0] epoch_number;
      logic [31:0] run_number;
      logic [31:0] sequence_number;
      logic [31:0] acked_number;
      logic [31:0] time_stamp;
   } result_type;

   // CRC-16/CCITT, MSB first, one byte.
   function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC16_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC16_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Reflected CRC-32, LSB first, one byte.
   function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h000000, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = {1'b0, c[31:1]} ^ CRC32_POLY;
         end else begin
            c = {1'b0, c[31:1]};
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/sfv_stream_if.sv
// ----------------------------------------------------------------------------
// Frame validator channels
// Valid/ready channels for frame bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface sfv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface sfv_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  verdict;
   logic [7:0]  kind;
   logic [7:0]  flag_bits;
   logic [7:0]  sender_slot;
   logic [7:0]  receiver_mask;
   logic [15:0] body_length;
   logic [31:0] epoch_number;
   logic [31:0] run_number;
   logic [31:0] sequence_number;
   logic [31:0] acked_number;
   logic [31:0] time_stamp;

   modport source (
      output valid, output verdict, output kind, output flag_bits, output sender_slot,
      output receiver_mask, output body_length, output epoch_number, output run_number,
      output sequence_number, output acked_number, output time_stamp, input ready
   );
   modport sink (
      input valid, input verdict, input kind, input flag_bits, input sender_slot,
      input receiver_mask, input body_length, input epoch_number, input run_number,
      input sequence_number, input acked_number, input time_stamp, output ready
   );
endinterface

FILE: rtl/core/sfv_check.sv
// ----------------------------------------------------------------------------
// Frame validator verdict logic
// Decodes the header and runs the ordered checks for one finished frame.
// ----------------------------------------------------------------------------
module sfv_check (
   input  sfv_pkg::header_type             hdr,
   input  logic [sfv_pkg::POS_W-1:0]       frame_len,
   input  logic [15:0]                     hdr_crc,
   input  logic [31:0]                     pay_crc,
   input  sfv_pkg::cfg_type                cfg,
   output sfv_pkg::result_type             result
);

   logic [15:0]               magic;
   logic [15:0]               plen;
   logic [15:0]               hdr_crc_field;
   logic [31:0]               pay_crc_field;
   logic [sfv_pkg::POS_W-1:0] need_len;
   sfv_pkg::verdict_type      verdict;

   assign magic         = {hdr[sfv_pkg::OFS_MAGIC+1], hdr[sfv_pkg::OFS_MAGIC]};
   assign plen          = {hdr[sfv_pkg::OFS_PAY_SIZE+1], hdr[sfv_pkg::OFS_PAY_SIZE]};
   assign hdr_crc_field = {hdr[sfv_pkg::OFS_HDR_CRC+1], hdr[sfv_pkg::OFS_HDR_CRC]};
   assign pay_crc_field = {hdr[sfv_pkg::OFS_PAY_CRC+3], hdr[sfv_pkg::OFS_PAY_CRC+2],
                           hdr[sfv_pkg::OFS_PAY_CRC+1], hdr[sfv_pkg::OFS_PAY_CRC]};
   assign need_len      = {1'b0, plen} + sfv_pkg::POS_W'(sfv_pkg::HEADER_BYTES);

   // Checks in priority order; the first failure wins.
   always_comb begin
      if (magic != cfg.magic) begin
         verdict = sfv_pkg::VERDICT_MAGIC;
      end else if (hdr[sfv_pkg::OFS_VERSION] != cfg.version) begin
         verdict = sfv_pkg::VERDICT_VERSION;
      end else if (hdr[sfv_pkg::OFS_KIND] < cfg.low_type ||
                   hdr[sfv_pkg::OFS_KIND] > cfg.high_type) begin
         verdict = sfv_pkg::VERDICT_TYPE;
      end else if (hdr[sfv_pkg::OFS_HDR_SIZE] != 8'(sfv_pkg::HEADER_BYTES)) begin
         verdict = sfv_pkg::VERDICT_HDR_SIZE;
      end else if (plen > cfg.pay_limit) begin
         verdict = sfv_pkg::VERDICT_PAYLIMIT;
      end else if (frame_len < need_len) begin
         verdict = sfv_pkg::VERDICT_SIZE;
      end else if (hdr_crc_field != hdr_crc) begin
         verdict = sfv_pkg::VERDICT_HDR_CRC;
      end else if (pay_crc_field != (pay_crc ^ sfv_pkg::CRC32_XOR)) begin
         verdict = sfv_pkg::VERDICT_PAY_CRC;
      end else begin
         verdict = sfv_pkg::VERDICT_OK;
      end
   end

   always_comb begin
      if (frame_len < sfv_pkg::POS_W'(sfv_pkg::HEADER_BYTES)) begin
         // A frame shorter than the header reports nothing decoded.
         result         = '0;
         result.verdict = sfv_pkg::VERDICT_SIZE;
      end else begin
         result.verdict         = verdict;
         result.kind            = hdr[sfv_pkg::OFS_KIND];
         result.flag_bits       = hdr[sfv_pkg::OFS_FLAGS];
         result.sender_slot     = hdr[sfv_pkg::OFS_SENDER];
         result.receiver_mask   = hdr[sfv_pkg::OFS_RECEIVER];
         result.body_length     = plen;
         result.epoch_number    = {hdr[sfv_pkg::OFS_EPOCH+3], hdr[sfv_pkg::OFS_EPOCH+2],
                                   hdr[sfv_pkg::OFS_EPOCH+1], hdr[sfv_pkg::OFS_EPOCH]};
         result.run_number      = {hdr[sfv_pkg::OFS_RUN+3], hdr[sfv_pkg::OFS_RUN+2],
                                   hdr[sfv_pkg::OFS_RUN+1], hdr[sfv_pkg::OFS_RUN]};
         result.sequence_number = {hdr[sfv_pkg::OFS_SEQUENCE+3], hdr[sfv_pkg::OFS_SEQUENCE+2],
                                   hdr[sfv_pkg::OFS_SEQUENCE+1], hdr[sfv_pkg::OFS_SEQUENCE]};
         result.acked_number    = {hdr[sfv_pkg::OFS_ACKED+3], hdr[sfv_pkg::OFS_ACKED+2],
                                   hdr[sfv_pkg::OFS_ACKED+1], hdr[sfv_pkg::OFS_ACKED]};
         result.time_stamp      = {hdr[sfv_pkg::OFS_TIME+3], hdr[sfv_pkg::OFS_TIME+2],
                                   hdr[sfv_pkg::OFS_TIME+1], hdr[sfv_pkg::OFS_TIME]};
      end
   end

endmodule

FILE: rtl/core/sync_frame_validator_crc.sv
// ----------------------------------------------------------------------------
// Synchronous frame validator with CRC checks
// Byte-stream frame header decoder with CRC-16 header and CRC-32 payload checks.
// ----------------------------------------------------------------------------
// The block takes one frame byte per request, at up to one request every
// clock cycle, with frame_end set on the last byte of the frame. Each byte is
// folded into the running state (header capture, byte-wide CRC-16 and CRC-32
// updates) in the cycle it is accepted. On the last byte, the verdict and the
// decoded header fields are formed in that same cycle and loaded into the
// response register, so a verdict appears in the cycle after the final byte is
// accepted. The request side is ready whenever the response register is
// empty or its verdict is taken in the same cycle. Frames therefore stream
// at one byte per cycle while the receiver keeps up. While a verdict is held
// and the receiver is not ready, no request of any kind is accepted, and the
// stall lasts until the verdict is taken.
// Configuration registers may be written at any time the block is idle and
// take effect on the next frame end.
module sync_frame_validator_crc (
   input  logic                              clock,
   input  logic                              reset,
   sfv_req_if.sink                           req_chan,
   sfv_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [sfv_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sfv_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // Configuration registers.
   sfv_pkg::cfg_type cfg_ff;

   // Per-frame state.
   logic [sfv_pkg::POS_W-1:0]    pos_ff;
   logic [sfv_pkg::POS_W-1:0]    pos_in;
   logic [15:0]                  hcrc_ff;
   logic [15:0]                  hcrc_in;
   logic [31:0]                  bcrc_ff;
   logic [31:0]                  bcrc_in;
   logic [sfv_pkg::REMAIN_W-1:0] brem_ff;
   logic [sfv_pkg::REMAIN_W-1:0] brem_in;
   sfv_pkg::header_type          hdr_ff;
   sfv_pkg::header_type          hdr_in;

   // Response register.
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   sfv_pkg::result_type          rsp_ff;
   sfv_pkg::result_type          result;

   logic                         accept;
   logic                         in_hdr;
   logic [5:0]                   hdr_idx;
   logic                         crc_gap;
   logic                         pay_size_byte;
   logic                         pos_sat;

   // A held verdict that the receiver is not taking stalls every request, so
   // the response register is never overwritten.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign in_hdr        = pos_ff < sfv_pkg::POS_W'(sfv_pkg::HEADER_BYTES);
   assign hdr_idx       = pos_ff[5:0];
   assign crc_gap       = in_hdr && (hdr_idx == 6'(sfv_pkg::OFS_HDR_CRC) ||
                                     hdr_idx == 6'(sfv_pkg::OFS_HDR_CRC + 1));
   assign pay_size_byte = in_hdr && (hdr_idx == 6'(sfv_pkg::OFS_PAY_SIZE) ||
                                     hdr_idx == 6'(sfv_pkg::OFS_PAY_SIZE + 1));
   assign pos_sat       = pos_ff == sfv_pkg::POS_MAX;

   // Header view including the byte being accepted, so that a frame ending
   // on the last header byte sees the whole header.
   always_comb begin
      for (int k = 0; k < sfv_pkg::HEADER_BYTES; k++) begin
         if (in_hdr && hdr_idx == 6'(k)) begin
            hdr_in[k] = req_chan.data_byte;
         end else begin
            hdr_in[k] = hdr_ff[k];
         end
      end
   end

   // Running checks. The header CRC sees the CRC field itself as zero bytes.
   always_comb begin
      hcrc_in = hcrc_ff;
      bcrc_in = bcrc_ff;
      brem_in = brem_ff;
      if (in_hdr) begin
         hcrc_in = sfv_pkg::crc16_byte(hcrc_ff, crc_gap ? 8'h00 : req_chan.data_byte);
         if (pay_size_byte) begin
            bcrc_in = sfv_pkg::crc32_byte(bcrc_ff, req_chan.data_byte);
         end
         if (hdr_idx == 6'(sfv_pkg::HEADER_BYTES - 1)) begin
            brem_in = {hdr_ff[sfv_pkg::OFS_PAY_SIZE+1], hdr_ff[sfv_pkg::OFS_PAY_SIZE]};
         end
      end else if (brem_ff != '0) begin
         // Bytes beyond the declared payload leave the CRC alone.
         bcrc_in = sfv_pkg::crc32_byte(bcrc_ff, req_chan.data_byte);
         brem_in = brem_ff - 1'b1;
      end
      pos_in = pos_sat ? pos_ff : pos_ff + 1'b1;
   end

   sfv_check u_check (
      .hdr       (hdr_in),
      .frame_len (pos_in),
      .hdr_crc   (hcrc_in),
      .pay_crc   (bcrc_in),
      .cfg       (cfg_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic     <= '0;
         cfg_ff.version   <= '0;
         cfg_ff.low_type  <= 8'd1;
         cfg_ff.high_type <= 8'd255;
         cfg_ff.pay_limit <= 16'hFFFF;
      end else if (csr_we) begin
         unique case (sfv_pkg::csr_index_type'(csr_index))
            sfv_pkg::CSR_MAGIC:     cfg_ff.magic     <= csr_wdata[15:0];
            sfv_pkg::CSR_VERSION:   cfg_ff.version   <= csr_wdata[7:0];
            sfv_pkg::CSR_LOW_TYPE:  cfg_ff.low_type  <= csr_wdata[7:0];
            sfv_pkg::CSR_HIGH_TYPE: cfg_ff.high_type <= csr_wdata[7:0];
            sfv_pkg::CSR_PAY_LIMIT: cfg_ff.pay_limit <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Frame state returns to its start values after every frame end.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         hcrc_ff <= sfv_pkg::CRC16_INIT;
         bcrc_ff <= sfv_pkg::CRC32_INIT;
         brem_ff <= '0;
      end else if (accept) begin
         if (req_chan.frame_end) begin
            pos_ff  <= '0;
            hcrc_ff <= sfv_pkg::CRC16_INIT;
            bcrc_ff <= sfv_pkg::CRC32_INIT;
            brem_ff <= '0;
         end else begin
            pos_ff  <= pos_in;
            hcrc_ff <= hcrc_in;
            bcrc_ff <= bcrc_in;
            brem_ff <= brem_in;
         end
      end
   end

   // The header store is only read once the current frame has filled it.
   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff <= hdr_in;
      end
   end

   always_comb begin
      if (accept && req_chan.frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_chan.frame_end) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.verdict         = rsp_ff.verdict;
   assign rsp_chan.kind            = rsp_ff.kind;
   assign rsp_chan.flag_bits       = rsp_ff.flag_bits;
   assign rsp_chan.sender_slot     = rsp_ff.sender_slot;
   assign rsp_chan.receiver_mask   = rsp_ff.receiver_mask;
   assign rsp_chan.body_length     = rsp_ff.body_length;
   assign rsp_chan.epoch_number    = rsp_ff.epoch_number;
   assign rsp_chan.run_number      = rsp_ff.run_number;
   assign rsp_chan.sequence_number = rsp_ff.sequence_number;
   assign rsp_chan.acked_number    = rsp_ff.acked_number;
   assign rsp_chan.time_stamp      = rsp_ff.time_stamp;

   // A frame end always produces a verdict in the next cycle.
   a_end_gives_verdict: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.frame_end |=> rsp_chan.valid)
      else $error("frame end did not produce a verdict");

   // After a frame end the per-frame state is back at its start values.
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.frame_end |=>
         pos_ff == '0 && hcrc_ff == sfv_pkg::CRC16_INIT &&
         bcrc_ff == sfv_pkg::CRC32_INIT && brem_ff == '0)
      else $error("frame state not restarted after frame end");

   // Payload bytes are only counted once the header is complete.
   a_payload_after_header: assert property (@(posedge clock) disable iff (reset)
      brem_ff != '0 |-> pos_ff >= sfv_pkg::POS_W'(sfv_pkg::HEADER_BYTES))
      else $error("payload count active inside the header");

   // No request, and so no second frame end, is accepted while a verdict is held and not taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !accept)
      else $error("request accepted over a held verdict");

endmodule
